// File: rtl/ihu_pkg.sv
// Shared types and constants of the indexed min-heap update block.
package ihu_pkg;

  localparam int SLOT_W = 10;
  localparam int LEN_W = 11;
  localparam int HANDLE_W = 16;
  localparam int NEW_KEY_W = 64;
  localparam int MAX_RESULTS = 11;
  localparam int CNT_W = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAR_RD,
    S_PAR_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP
  } state_t;

  typedef enum logic [1:0] {
    RD_PAR,
    RD_LC,
    RD_RC
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    take_lc;
    logic    move_up;
    logic    move_dn;
    logic    place;
  } cmd_t;

  typedef struct packed {
    logic in_drop;
    logic in_direct;
    logic in_root;
    logic par_gt;
    logic par_root;
    logic lc_ok;
    logic rc_ok;
    logic found_any;
    logic move_ok;
    logic out_free;
  } status_t;

endpackage

// File: rtl/ihu_req_if.sv
// Request channel interface: one new heap entry and the current heap length.
interface ihu_req_if;
  logic                            valid;
  logic                            ready;
  logic [ihu_pkg::SLOT_W-1:0]      slot;
  logic [ihu_pkg::LEN_W-1:0]       heap_length;
  logic [ihu_pkg::NEW_KEY_W-1:0]   new_key;
  logic [ihu_pkg::HANDLE_W-1:0]    entry_handle;

  modport source (output valid, slot, heap_length, new_key, entry_handle, input ready);
  modport sink (input valid, slot, heap_length, new_key, entry_handle, output ready);
endinterface

// File: rtl/ihu_res_if.sv
// Result channel interface: one placement of an entry at a heap slot.
interface ihu_res_if;
  logic                         valid;
  logic                         ready;
  logic [ihu_pkg::HANDLE_W-1:0] moved_handle;
  logic [ihu_pkg::SLOT_W-1:0]   moved_slot;
  logic                         last_move;

  modport source (output valid, moved_handle, moved_slot, last_move, input ready);
  modport sink (input valid, moved_handle, moved_slot, last_move, output ready);
endinterface

// File: rtl/indexed_min_heap_update.sv
// Top level of the indexed min-heap update block: controller, datapath and channels.
//
//   Channel  Dir  Payload                                    Moves
//   req      in   slot, heap_length, new_key, entry_handle   one request per entry update
//   res      out  moved_handle, moved_slot, last_move        up to MAX_RESULTS per update
//
// A request is accepted in the idle state. Each level the entry climbs or tests on the way up
// takes a parent read and a compare, each level down a left read, a right read and a compare,
// set by the single read port of the heap memory; a leaf test ends at the left read, then the
// final placement. Worst case at the default depth: a sift-down from the root to slot 1023.
// Reset clears only the control state; the heap memory is not cleared.
// A stalled result channel holds the sequencer at the next placement that emits a result until it drains.
module indexed_min_heap_update #(
  parameter int DEPTH = 1024,
  parameter int KEY_WIDTH = 64
) (
  input logic     clk,
  input logic     rst,
  ihu_req_if.sink req,
  ihu_res_if.source res
);

  ihu_pkg::cmd_t    cmd;
  ihu_pkg::status_t st;

  ihu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ihu_dpath #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .slot        (req.slot),
    .heap_length (req.heap_length),
    .new_key     (req.new_key),
    .entry_handle(req.entry_handle),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .moved_handle(res.moved_handle),
    .moved_slot  (res.moved_slot),
    .last_move   (res.last_move)
  );

endmodule

// File: rtl/ihu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihu_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ihu_ctrl.sv
// Controller state machine that sequences the sift of one entry through the heap.
module ihu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ihu_pkg::status_t st,
  output ihu_pkg::cmd_t    cmd
);

  ihu_pkg::state_t state, state_next;
  logic final_pending, final_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihu_pkg::S_IDLE;
      final_pending <= 1'b0;
    end else begin
      state <= state_next;
      final_pending <= final_pending_next;
    end
  end

  always_comb begin
    state_next = state;
    final_pending_next = final_pending;
    cmd = '0;
    cmd.rd_sel = ihu_pkg::RD_PAR;
    req_ready = 1'b0;
    if (final_pending) begin
      if (st.out_free) begin
        cmd.place = 1'b1;
        final_pending_next = 1'b0;
        state_next = ihu_pkg::S_IDLE;
      end
    end else begin
      case (state)
        ihu_pkg::S_IDLE: begin
          req_ready = 1'b1;
          if (req_valid) begin
            cmd.load = 1'b1;
            if (st.in_drop) begin
              state_next = ihu_pkg::S_IDLE;
            end else if (st.in_direct) begin
              final_pending_next = 1'b1;
            end else if (st.in_root) begin
              state_next = ihu_pkg::S_DN_RDL;
            end else begin
              state_next = ihu_pkg::S_PAR_RD;
            end
          end
        end
        ihu_pkg::S_PAR_RD, ihu_pkg::S_UP_RD: begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = ihu_pkg::RD_PAR;
          state_next = (state == ihu_pkg::S_PAR_RD) ? ihu_pkg::S_PAR_CMP : ihu_pkg::S_UP_CMP;
        end
        ihu_pkg::S_PAR_CMP, ihu_pkg::S_UP_CMP: begin
          if (st.par_gt) begin
            if (st.move_ok) begin
              cmd.move_up = 1'b1;
              if (st.par_root) begin
                final_pending_next = 1'b1;
              end else begin
                state_next = ihu_pkg::S_UP_RD;
              end
            end
          end else if (state == ihu_pkg::S_PAR_CMP) begin
            state_next = ihu_pkg::S_DN_RDL;
          end else begin
            final_pending_next = 1'b1;
          end
        end
        ihu_pkg::S_DN_RDL: begin
          if (st.lc_ok) begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = ihu_pkg::RD_LC;
            state_next = ihu_pkg::S_DN_RDR;
          end else begin
            final_pending_next = 1'b1;
          end
        end
        ihu_pkg::S_DN_RDR: begin
          cmd.take_lc = 1'b1;
          cmd.rd_en = st.rc_ok;
          cmd.rd_sel = ihu_pkg::RD_RC;
          state_next = ihu_pkg::S_DN_CMP;
        end
        ihu_pkg::S_DN_CMP: begin
          if (!st.found_any) begin
            final_pending_next = 1'b1;
          end else if (st.move_ok) begin
            cmd.move_dn = 1'b1;
            state_next = ihu_pkg::S_DN_RDL;
          end
        end
        default: begin
          state_next = ihu_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/ihu_dpath.sv
// Datapath: entry registers, heap memory, key comparators and the result register.
module ihu_dpath #(
  parameter int DEPTH = 1024,
  parameter int KEY_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ihu_pkg::cmd_t                   cmd,
  output ihu_pkg::status_t                st,
  input  logic [ihu_pkg::SLOT_W-1:0]      slot,
  input  logic [ihu_pkg::LEN_W-1:0]       heap_length,
  input  logic [ihu_pkg::NEW_KEY_W-1:0]   new_key,
  input  logic [ihu_pkg::HANDLE_W-1:0]    entry_handle,
  input  logic                            res_ready,
  output logic                            res_valid,
  output logic [ihu_pkg::HANDLE_W-1:0]    moved_handle,
  output logic [ihu_pkg::SLOT_W-1:0]      moved_slot,
  output logic                            last_move
);

  localparam int AW = $clog2(DEPTH);
  localparam int HW = ihu_pkg::HANDLE_W;
  localparam int EW = KEY_WIDTH + HW;

  logic [ihu_pkg::LEN_W-1:0]  pos, best_idx;
  logic [ihu_pkg::LEN_W-1:0]  len;
  logic [KEY_WIDTH-1:0]       key, best_key;
  logic [HW-1:0]              hdl, best_hdl;
  logic                       found;
  logic [ihu_pkg::CNT_W-1:0]  count;

  logic [ihu_pkg::LEN_W-1:0]  len_in;
  logic [ihu_pkg::LEN_W-1:0]  par;
  logic [ihu_pkg::LEN_W:0]    lc;
  logic [ihu_pkg::LEN_W:0]    rc;
  logic [ihu_pkg::LEN_W-1:0]  rd_idx;
  logic [EW-1:0]              rdata, wdata;
  logic                       we;
  logic [KEY_WIDTH-1:0]       rkey, ref_key;
  logic [HW-1:0]              rhdl;
  logic                       lc_lt, rc_ok, sel_rc, may_emit, emit;
  logic [KEY_WIDTH-1:0]       ch_key;
  logic [HW-1:0]              ch_hdl;
  logic [ihu_pkg::LEN_W-1:0]  ch_idx;

  assign len_in = (32'(heap_length) > 32'(DEPTH)) ? ihu_pkg::LEN_W'(DEPTH) : heap_length;
  assign par = (pos - ihu_pkg::LEN_W'(1)) >> 1;
  assign lc = {pos, 1'b1};
  assign rc = {pos, 1'b0} + (ihu_pkg::LEN_W+1)'(2);

  assign rkey = rdata[EW-1:HW];
  assign rhdl = rdata[HW-1:0];

  assign lc_lt = rkey < key;
  assign rc_ok = rc < {1'b0, len};
  assign ref_key = found ? best_key : key;
  assign sel_rc = rc_ok && (rkey < ref_key);
  assign ch_key = sel_rc ? rkey : best_key;
  assign ch_hdl = sel_rc ? rhdl : best_hdl;
  assign ch_idx = sel_rc ? ihu_pkg::LEN_W'(rc) : best_idx;

  assign may_emit = count < ihu_pkg::CNT_W'(ihu_pkg::MAX_RESULTS - 1);

  always_comb begin
    st.in_drop = 32'(slot) >= 32'(DEPTH);
    st.in_direct = {1'b0, slot} >= len_in;
    st.in_root = slot == '0;
    st.par_gt = rkey > key;
    st.par_root = pos <= ihu_pkg::LEN_W'(2);
    st.lc_ok = lc < {1'b0, len};
    st.rc_ok = rc_ok;
    st.found_any = found || sel_rc;
    st.out_free = !res_valid || res_ready;
    st.move_ok = !may_emit || !res_valid || res_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      ihu_pkg::RD_PAR: rd_idx = par;
      ihu_pkg::RD_LC:  rd_idx = ihu_pkg::LEN_W'(lc);
      ihu_pkg::RD_RC:  rd_idx = ihu_pkg::LEN_W'(rc);
      default:         rd_idx = par;
    endcase
  end

  always_comb begin
    we = cmd.move_up || cmd.move_dn || cmd.place;
    if (cmd.move_up) begin
      wdata = rdata;
    end else if (cmd.move_dn) begin
      wdata = {ch_key, ch_hdl};
    end else begin
      wdata = {key, hdl};
    end
  end

  ihu_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(pos)),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(AW'(rd_idx)),
    .rdata(rdata)
  );

  assign emit = ((cmd.move_up || cmd.move_dn) && may_emit) || cmd.place;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos <= {1'b0, slot};
      len <= len_in;
      key <= new_key[KEY_WIDTH-1:0];
      hdl <= entry_handle;
      count <= '0;
    end else if (cmd.move_up) begin
      pos <= par;
    end else if (cmd.move_dn) begin
      pos <= ch_idx;
    end
    if ((cmd.move_up || cmd.move_dn) && may_emit) begin
      count <= count + ihu_pkg::CNT_W'(1);
    end
    if (cmd.take_lc) begin
      found <= lc_lt;
      best_key <= rkey;
      best_hdl <= rhdl;
      best_idx <= ihu_pkg::LEN_W'(lc);
    end
    if (emit) begin
      moved_slot <= pos[ihu_pkg::SLOT_W-1:0];
      last_move <= cmd.place;
      if (cmd.move_up) begin
        moved_handle <= rhdl;
      end else if (cmd.move_dn) begin
        moved_handle <= ch_hdl;
      end else begin
        moved_handle <= hdl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit || (res_valid && !res_ready);
    end
  end

endmodule
